// File: rtl/core/rfcrc5_pkg.sv
// Shared constants, types and lookup functions for the RF symbol CRC-5 receiver.
`timescale 1ns / 1ps

package rfcrc5_pkg;

    localparam logic [7:0] CODE_SYNC_LO = 8'h11;
    localparam logic [7:0] CODE_SYNC_HI = 8'h13;
    localparam logic [7:0] CODE_NONE    = 8'hff;
    localparam logic [7:0] CRC_INIT     = 8'h1f;
    localparam logic [7:0] CRC_HDR_MASK = 8'he0;
    localparam logic [4:0] CRC_XOROUT   = 5'h1f;
    localparam logic [7:0] CRC_MULT     = 8'h0e;
    localparam logic [5:0] CRC_POLY     = 6'h29;

    typedef struct packed {
        logic        emit;
        logic [31:0] payload;
        logic        crc_ok;
    } t_frame_res;

    // Symbol ROM: line byte to code, unlisted bytes give CODE_NONE.
    function automatic logic [7:0] sym_decode(input logic [7:0] b);
        logic [7:0] code;
        case (b)
            8'h66: code = 8'h00;
            8'h56: code = 8'h01;
            8'ha6: code = 8'h02;
            8'h6a: code = 8'h03;
            8'h96: code = 8'h04;
            8'h36: code = 8'h05;
            8'h5a: code = 8'h06;
            8'haa: code = 8'h07;
            8'h9a: code = 8'h08;
            8'hb2: code = 8'h09;
            8'h4d: code = 8'h0a;
            8'h65: code = 8'h0b;
            8'h4b: code = 8'h0c;
            8'h55: code = 8'h0d;
            8'ha5: code = 8'h0e;
            8'h2d: code = 8'h0f;
            8'hc0: code = 8'h10;
            8'he0: code = 8'h11;
            8'hf0: code = 8'h12;
            8'hf8: code = 8'h13;
            8'hfc: code = 8'h14;
            default: code = CODE_NONE;
        endcase
        return code;
    endfunction

    // Byte-wise CRC step: v * (x^3+x^2+x) mod (x^5+x^3+1).
    function automatic logic [4:0] crc_step(input logic [7:0] v);
        logic [10:0] prod;
        prod = '0;
        for (int k = 0; k < 8; k++) begin
            if (v[k]) begin
                prod = prod ^ (11'(CRC_MULT) << k);
            end
        end
        for (int k = 10; k >= 5; k--) begin
            if (prod[k]) begin
                prod = prod ^ (11'(CRC_POLY) << (k - 5));
            end
        end
        return prod[4:0];
    endfunction

endpackage

// File: rtl/core/rfcrc5_frame.sv
// Frame tracker: symbol decode, phase sequencer, packet bytes and running CRC-5.
`timescale 1ns / 1ps

module rfcrc5_frame (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [7:0]              i_rx_byte,
    output rfcrc5_pkg::t_frame_res  o_res
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_SYNC = 4'd1,
        PH_SOF  = 4'd2,
        PH_B0H  = 4'd3,
        PH_B1L  = 4'd4,
        PH_B1H  = 4'd5,
        PH_B2L  = 4'd6,
        PH_B2H  = 4'd7,
        PH_B3L  = 4'd8,
        PH_B3H  = 4'd9
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_bytes [4];
    logic [7:0] n_bytes [4];
    logic [4:0] r_crc, n_crc;
    logic [4:0] r_fsc, n_fsc;

    logic [7:0] w_code;
    logic [7:0] w_hi;
    logic       w_sync;
    logic [7:0] w_b3;
    logic [4:0] w_crc_fin;

    assign w_code = rfcrc5_pkg::sym_decode(i_rx_byte);
    assign w_hi   = {w_code[3:0], 4'b0000};
    assign w_sync = (w_code >= rfcrc5_pkg::CODE_SYNC_LO) &&
                    (w_code <= rfcrc5_pkg::CODE_SYNC_HI);
    assign w_b3   = r_bytes[3] | w_hi;
    assign w_crc_fin = rfcrc5_pkg::crc_step({3'b000, r_crc} ^ w_b3) ^ rfcrc5_pkg::CRC_XOROUT;

    always_comb begin
        o_res.emit    = !w_sync && (r_phase == PH_B3H);
        o_res.payload = {r_bytes[0][7:5], 5'b00000, r_bytes[1], r_bytes[2], w_b3};
        o_res.crc_ok  = (w_crc_fin == r_fsc);
    end

    always_comb begin
        n_phase = r_phase;
        n_bytes = r_bytes;
        n_crc   = r_crc;
        n_fsc   = r_fsc;
        if (w_sync) begin
            if (r_phase == PH_SYNC) begin
                n_phase = PH_SOF;
            end else if (r_phase != PH_SOF) begin
                n_phase = PH_SYNC;
            end
        end else begin
            case (r_phase)
                PH_SOF: begin
                    n_bytes[0] = w_code;
                    n_phase    = PH_B0H;
                end
                PH_B0H: begin
                    // byte0 done: seed the CRC with its header bits, keep the check field
                    n_bytes[0] = r_bytes[0] | w_hi;
                    n_fsc      = n_bytes[0][4:0];
                    n_crc      = rfcrc5_pkg::crc_step(rfcrc5_pkg::CRC_INIT ^
                                 (n_bytes[0] & rfcrc5_pkg::CRC_HDR_MASK));
                    n_phase    = PH_B1L;
                end
                PH_B1L: begin
                    n_bytes[1] = w_code;
                    n_phase    = PH_B1H;
                end
                PH_B1H: begin
                    n_bytes[1] = r_bytes[1] | w_hi;
                    n_crc      = rfcrc5_pkg::crc_step({3'b000, r_crc} ^ n_bytes[1]);
                    n_phase    = PH_B2L;
                end
                PH_B2L: begin
                    n_bytes[2] = w_code;
                    n_phase    = PH_B2H;
                end
                PH_B2H: begin
                    n_bytes[2] = r_bytes[2] | w_hi;
                    n_crc      = rfcrc5_pkg::crc_step({3'b000, r_crc} ^ n_bytes[2]);
                    n_phase    = PH_B3L;
                end
                PH_B3L: begin
                    n_bytes[3] = w_code;
                    n_phase    = PH_B3H;
                end
                PH_B3H: begin
                    n_bytes[3] = w_b3;
                    n_phase    = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
        if (i_step) begin
            r_bytes <= n_bytes;
            r_crc   <= n_crc;
            r_fsc   <= n_fsc;
        end
    end

    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.emit |=> r_phase == PH_IDLE)
        else $error("phase did not return to idle after a packet");

    a_sync_pair_sof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_sync && r_phase == PH_SYNC |=> r_phase == PH_SOF)
        else $error("second sync did not reach start-of-frame");

    a_emit_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.emit |-> r_phase == PH_B3H)
        else $error("packet emitted outside the last nibble");

endmodule

// File: rtl/core/rf_symbol_packet_crc5_receiver_unit.sv
// A packet's last byte waits in the input register; its step fills the result register.
// Throughput: one byte per cycle when not stalled; the frame step runs on each held byte.
// Only a packet-completing byte waits on a stalled, still-full result register.
// Reset (i_rst_n low, synchronous): phase to idle, input and result registers empty.
// Packet bytes and CRC state are payload and are loaded as the frame fills.
`timescale 1ns / 1ps

module rf_symbol_packet_crc5_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [31:0] o_payload,
    output logic        o_crc_ok
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic [31:0] r_payload;
    logic        r_crc_ok;

    rfcrc5_pkg::t_frame_res w_res;
    logic                   w_step;

    rfcrc5_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_rx_byte (r_in_byte),
        .o_res     (w_res)
    );

    // Advance unless this beat produces a result and the result slot stays occupied.
    assign w_step     = r_in_valid && (!w_res.emit || !r_out_valid || !i_res_stall);
    assign o_rx_stall = r_in_valid && !w_step;

    assign o_res_valid = r_out_valid;
    assign o_payload   = r_payload;
    assign o_crc_ok    = r_crc_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx_valid && !o_rx_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step && w_res.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_rx_valid && !o_rx_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_step && w_res.emit) begin
            r_payload <= w_res.payload;
            r_crc_ok  <= w_res.crc_ok;
        end
    end

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_result_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_step && w_res.emit))
        else $error("result appeared without a completing beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_res_stall |-> !(w_step && w_res.emit))
        else $error("pending result overwritten");

endmodule
